// ===== rtl/vps_pkg.sv =====
// ----------------------------------------------------------------------------
// vps_pkg
// Shared types, constants and saturation helpers for the VTI PML pressure
// stencil update unit.
// ----------------------------------------------------------------------------
package vps_pkg;

    localparam int STENCIL_HALF_DEF = 8;
    localparam int COEF_NUM         = 8;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 64;
    localparam logic signed [63:0] ONE_Q   = 64'sd65536;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP    = 3'd0,
        REG_STEP_OVER_DZ = 3'd1,
        REG_ETA          = 3'd2,
        REG_SOURCE_AMP   = 3'd3,
        REG_COEF_12      = 3'd4,
        REG_COEF_34      = 3'd5,
        REG_COEF_56      = 3'd6,
        REG_COEF_78      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic               first_of_column;
        logic signed [31:0] vz_lead;
        logic signed [31:0] theta_lead;
        logic signed [31:0] px_now;
        logic signed [31:0] pz_now;
        logic        [30:0] absorb_x;
        logic        [30:0] absorb_z;
        logic        [30:0] vel;
        logic        [30:0] vel_vertical;
        logic        [30:0] density;
        logic signed [31:0] k_now;
        logic               source_here;
    } in_t;

    typedef struct packed {
        logic signed [31:0] px_next;
        logic signed [31:0] pz_next;
        logic signed [31:0] p_next;
        logic               saturated;
    } out_t;

    // one stencil tap: both window differences and its coefficient
    typedef struct packed {
        logic signed [32:0] dvz;
        logic signed [32:0] dth;
        logic signed [31:0] coef;
    } tap_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7fffffff;
        else if (v < S32_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic clip32(input logic signed [63:0] v);
        return (v > S32_MAX) || (v < S32_MIN);
    endfunction

endpackage

// ===== rtl/vps_win_cell.sv =====
// ----------------------------------------------------------------------------
// vps_win_cell
// One window position: holds a vz and a theta sample, takes its neighbor's
// pair on each shift.
// ----------------------------------------------------------------------------
module vps_win_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift,
    input  logic signed [31:0] vz_in,
    input  logic signed [31:0] th_in,
    output logic signed [31:0] vz,
    output logic signed [31:0] th
);

    logic signed [31:0] vz_reg;
    logic signed [31:0] th_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vz_reg <= '0;
            th_reg <= '0;
        end
        else if (shift)
        begin
            vz_reg <= vz_in;
            th_reg <= th_in;
        end
    end

    assign vz = vz_reg;
    assign th = th_reg;

endmodule

// ===== rtl/vps_tap_cell.sv =====
// ----------------------------------------------------------------------------
// vps_tap_cell
// One stencil tap: loads its window differences and coefficient, then
// rotates along the tap ring so the multiplier always reads the head.
// ----------------------------------------------------------------------------
module vps_tap_cell (
    input  logic          clk,
    input  logic          load,
    input  logic          rotate,
    input  vps_pkg::tap_t load_val,
    input  vps_pkg::tap_t prev,
    output vps_pkg::tap_t tap
);

    vps_pkg::tap_t tap_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            tap_reg <= load_val;
        else if (rotate)
            tap_reg <= prev;
    end

    assign tap = tap_reg;

endmodule

// ===== rtl/vps_mul.sv =====
// ----------------------------------------------------------------------------
// vps_mul
// Q16.16 multiplier, sign-magnitude, truncating toward zero; one register
// stage on the product.
// ----------------------------------------------------------------------------
module vps_mul (
    input  logic               clk,
    input  logic signed [33:0] a,
    input  logic signed [33:0] b,
    output logic signed [51:0] q
);

    logic [33:0] ua;
    logic [33:0] ub;
    logic [65:0] prod_reg;
    logic        neg_reg;
    logic [51:0] pmag;

    assign ua = a[33] ? 34'(-a) : 34'(a);
    assign ub = b[33] ? 34'(-b) : 34'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= ua[32:0] * ub[32:0];
        neg_reg  <= a[33] ^ b[33];
    end

    assign pmag = {2'b00, prod_reg[65:16]};
    assign q    = neg_reg ? -$signed(pmag) : $signed(pmag);

endmodule

// ===== rtl/vps_div.sv =====
// ----------------------------------------------------------------------------
// vps_div
// Radix-2 restoring divider: (|num| << 16) / den, signed and saturated to
// 32 bits. done pulses as the quotient is registered after the last iteration.
// ----------------------------------------------------------------------------
module vps_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [48:0] num,
    input  logic        [31:0] den,
    output logic               done,
    output logic signed [31:0] quo,
    output logic               clip
);

    logic               busy_reg;
    logic [5:0]         cnt_reg;
    logic [63:0]        dvd_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        den_reg;
    logic               neg_reg;
    logic               done_reg;
    logic signed [31:0] quo_reg;
    logic               clip_reg;

    logic [48:0]        nmag;
    logic [32:0]        trial;
    logic               ge;
    logic [31:0]        rem_next;
    logic [63:0]        dvd_next;
    logic signed [64:0] sq;

    assign nmag     = num[48] ? 49'(-num) : 49'(num);
    assign trial    = {rem_reg, dvd_reg[63]};
    assign ge       = trial >= {1'b0, den_reg};
    assign rem_next = ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
    assign dvd_next = {dvd_reg[62:0], ge};
    assign sq       = neg_reg ? -$signed({1'b0, dvd_next}) : $signed({1'b0, dvd_next});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {nmag[47:0], 16'h0000};
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[48];
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
            if (cnt_reg == 6'd63)
            begin
                quo_reg  <= vps_pkg::sat32(sq[63:0]);
                clip_reg <= (dvd_next[63] && !neg_reg) || vps_pkg::clip32(sq[63:0]);
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign clip = clip_reg;

endmodule

// ===== rtl/vti_pml_pressure_stencil_update_unit.sv =====
// ----------------------------------------------------------------------------
// vti_pml_pressure_stencil_update_unit
// Streams one grid column; 2*STENCIL_HALF-deep (16 by default) vz/theta windows, PML-damped split
// pressure update with two antisymmetric z stencils, Q16.16 saturated.
// An item that only fills the window is taken in and the unit stays idle; an item after
// which the window is full yields a result, as one shared multiplier walks the factor
// chains and tap ring and one radix-2 divider runs twice. One item in flight at a time.
// Reset: windows, fill count and configuration registers clear; output empty.
// ----------------------------------------------------------------------------
module vti_pml_pressure_stencil_update_unit #(
    parameter int STENCIL_HALF = vps_pkg::STENCIL_HALF_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  vps_pkg::in_t                     in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output vps_pkg::out_t                    out_data,
    input  logic                             cfg_we,
    input  logic [vps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vps_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int WIN = 2 * STENCIL_HALF;
    localparam int FCW = $clog2(WIN + 1);
    localparam int KW  = (STENCIL_HALF > 1) ? $clog2(STENCIL_HALF) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_MUL  = 6'b000100,
        S_WB   = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    typedef enum logic [4:0] {
        P_V2, P_VV2, P_HX, P_HZ, P_T1, P_T2, P_T3, P_NX, P_SVZ, P_STH,
        P_PA1, P_PA2, P_PA3, P_PB1, P_PB2, P_PB3, P_PB4, P_NZ, P_SRC
    } step_t;

    state_t state_reg, state_next;
    step_t  step_reg;

    logic        [30:0] time_step_reg;
    logic        [30:0] sdz_reg;
    logic signed [31:0] eta_reg;
    logic signed [31:0] src_amp_reg;
    logic signed [31:0] coef_reg [vps_pkg::COEF_NUM];

    logic [FCW-1:0] fill_reg;
    logic [FCW-1:0] fill0;
    logic [FCW-1:0] fill_new;
    logic           in_acc;

    vps_pkg::in_t item_reg;

    logic signed [31:0] win_vz [WIN];
    logic signed [31:0] win_th [WIN];

    vps_pkg::tap_t tap_q    [STENCIL_HALF];
    vps_pkg::tap_t tap_load [STENCIL_HALF];
    logic          tap_ld;
    logic          tap_rot;

    logic signed [31:0] v2_reg, vv2_reg, hx_reg, hz_reg, t_reg, px_reg, pz_reg;
    logic signed [31:0] sv_reg, st_reg, pa_reg, pb_reg, src_reg;
    logic signed [55:0] acc_reg;
    logic [KW-1:0]      k_reg;
    logic               clip_reg;

    logic signed [33:0] op_a, op_b;
    logic signed [51:0] mq;
    logic signed [63:0] e1_raw, e2_raw;
    logic signed [55:0] acc_sum;
    logic signed [48:0] drive_z;
    logic signed [63:0] p_sum;

    logic               div_start;
    logic signed [48:0] div_num;
    logic        [31:0] div_den;
    logic               div_done;
    logic signed [31:0] div_q;
    logic               div_clip;

    logic               out_valid_reg;
    vps_pkg::out_t      out_data_reg;
    logic               out_load;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= '0;
            sdz_reg       <= '0;
            eta_reg       <= '0;
            src_amp_reg   <= '0;
            for (int i = 0; i < vps_pkg::COEF_NUM; i++)
                coef_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (vps_pkg::reg_idx_t'(cfg_index))
                vps_pkg::REG_TIME_STEP:    time_step_reg <= cfg_data[30:0];
                vps_pkg::REG_STEP_OVER_DZ: sdz_reg       <= cfg_data[30:0];
                vps_pkg::REG_ETA:          eta_reg       <= cfg_data[31:0];
                vps_pkg::REG_SOURCE_AMP:   src_amp_reg   <= cfg_data[31:0];
                vps_pkg::REG_COEF_12:
                begin
                    coef_reg[0] <= cfg_data[31:0];
                    coef_reg[1] <= cfg_data[63:32];
                end
                vps_pkg::REG_COEF_34:
                begin
                    coef_reg[2] <= cfg_data[31:0];
                    coef_reg[3] <= cfg_data[63:32];
                end
                vps_pkg::REG_COEF_56:
                begin
                    coef_reg[4] <= cfg_data[31:0];
                    coef_reg[5] <= cfg_data[63:32];
                end
                vps_pkg::REG_COEF_78:
                begin
                    coef_reg[6] <= cfg_data[31:0];
                    coef_reg[7] <= cfg_data[63:32];
                end
                default: ;
            endcase
        end
    end

    // input side and window
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && (state_reg == S_IDLE);
    assign fill0    = in_data.first_of_column ? '0 : fill_reg;
    assign fill_new = (fill0 < FCW'(WIN)) ? fill0 + FCW'(1) : fill0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (in_acc)
            fill_reg <= fill_new;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            item_reg <= in_data;
    end

    for (genvar i = 0; i < WIN; i++)
    begin : g_win
        logic signed [31:0] vz_src, th_src;
        if (i == WIN - 1)
        begin : g_lead
            assign vz_src = in_data.vz_lead;
            assign th_src = in_data.theta_lead;
        end
        else
        begin : g_mid
            assign vz_src = win_vz[i+1];
            assign th_src = win_th[i+1];
        end
        vps_win_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (in_acc),
            .vz_in (vz_src),
            .th_in (th_src),
            .vz    (win_vz[i]),
            .th    (win_th[i])
        );
    end

    // tap ring
    assign tap_ld  = (state_reg == S_LOAD);
    assign tap_rot = (state_reg == S_WB) && ((step_reg == P_SVZ) || (step_reg == P_STH));

    for (genvar k = 0; k < STENCIL_HALF; k++)
    begin : g_tap
        assign tap_load[k].dvz  = 33'(win_vz[STENCIL_HALF+k]) - 33'(win_vz[STENCIL_HALF-1-k]);
        assign tap_load[k].dth  = 33'(win_th[STENCIL_HALF+k]) - 33'(win_th[STENCIL_HALF-1-k]);
        assign tap_load[k].coef = coef_reg[k];
        vps_tap_cell u_tap (
            .clk      (clk),
            .load     (tap_ld),
            .rotate   (tap_rot),
            .load_val (tap_load[k]),
            .prev     (tap_q[(k+1) % STENCIL_HALF]),
            .tap      (tap_q[k])
        );
    end

    // shared multiplier
    assign e1_raw = (64'(eta_reg) <<< 1) + vps_pkg::ONE_Q;
    assign e2_raw = 64'(eta_reg) <<< 1;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            P_V2:  begin op_a = 34'(item_reg.vel);          op_b = 34'(item_reg.vel);          end
            P_VV2: begin op_a = 34'(item_reg.vel_vertical); op_b = 34'(item_reg.vel_vertical); end
            P_HX:  begin op_a = 34'(time_step_reg);         op_b = 34'(item_reg.absorb_x);     end
            P_HZ:  begin op_a = 34'(time_step_reg);         op_b = 34'(item_reg.absorb_z);     end
            P_T1:  begin op_a = 34'(time_step_reg);         op_b = 34'(vps_pkg::sat32(e1_raw)); end
            P_T2:  begin op_a = 34'(t_reg);                 op_b = 34'(v2_reg);                end
            P_T3:  begin op_a = 34'(t_reg);                 op_b = 34'(item_reg.k_now);        end
            P_NX:  begin op_a = 34'sd65536 - 34'(hx_reg);   op_b = 34'(item_reg.px_now);       end
            P_SVZ: begin op_a = 34'(tap_q[0].coef);         op_b = 34'(tap_q[0].dvz);          end
            P_STH: begin op_a = 34'(tap_q[0].coef);         op_b = 34'(tap_q[0].dth);          end
            P_PA1: begin op_a = 34'(vv2_reg);               op_b = 34'(item_reg.density);      end
            P_PA2: begin op_a = 34'(pa_reg);                op_b = 34'(sdz_reg);               end
            P_PA3: begin op_a = 34'(pa_reg);                op_b = 34'(sv_reg);                end
            P_PB1: begin op_a = 34'(vps_pkg::sat32(e2_raw)); op_b = 34'(v2_reg);               end
            P_PB2: begin op_a = 34'(pb_reg);                op_b = 34'(vv2_reg);               end
            P_PB3: begin op_a = 34'(pb_reg);                op_b = 34'(sdz_reg);               end
            P_PB4: begin op_a = 34'(pb_reg);                op_b = 34'(st_reg);                end
            P_NZ:  begin op_a = 34'sd65536 - 34'(hz_reg);   op_b = 34'(item_reg.pz_now);       end
            P_SRC: begin op_a = 34'(src_amp_reg);           op_b = 34'(time_step_reg);         end
            default: ;
        endcase
    end

    vps_mul u_mul (
        .clk (clk),
        .a   (op_a),
        .b   (op_b),
        .q   (mq)
    );

    assign acc_sum = acc_reg + 56'(mq);
    assign drive_z = -49'(pa_reg) - 49'(pb_reg);

    // divider
    assign div_start = (state_reg == S_WB) && ((step_reg == P_NX) || (step_reg == P_NZ));
    assign div_num   = (step_reg == P_NX) ? 49'(mq) + 49'(t_reg) : 49'(mq) + drive_z;
    assign div_den   = (step_reg == P_NX) ? 32'(hx_reg) + 32'd65536 : 32'(hz_reg) + 32'd65536;

    vps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q),
        .clip  (div_clip)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_acc && (fill_new == FCW'(WIN))) state_next = S_LOAD;
            S_LOAD: state_next = S_MUL;
            S_MUL:  state_next = S_WB;
            S_WB:
            begin
                if ((step_reg == P_NX) || (step_reg == P_NZ))
                    state_next = S_DIV;
                else if (step_reg == P_SRC)
                    state_next = S_OUT;
                else
                    state_next = S_MUL;
            end
            S_DIV:  if (div_done) state_next = S_MUL;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            step_reg <= P_V2;
            acc_reg  <= '0;
            k_reg    <= '0;
            clip_reg <= vps_pkg::clip32(e1_raw) || vps_pkg::clip32(e2_raw);
        end
        else if (state_reg == S_DIV && div_done)
        begin
            clip_reg <= clip_reg || div_clip;
            if (step_reg == P_NX)
            begin
                px_reg   <= div_q;
                step_reg <= P_SVZ;
            end
            else
            begin
                pz_reg   <= div_q;
                step_reg <= P_SRC;
            end
        end
        else if (state_reg == S_WB)
        begin
            case (step_reg)
                P_V2:
                begin
                    v2_reg   <= vps_pkg::sat32(64'(mq));
                    clip_reg <= clip_reg || vps_pkg::clip32(64'(mq));
                    step_reg <= P_VV2;
                end
                P_VV2:
                begin
                    vv2_reg  <= vps_pkg::sat32(64'(mq));
                    clip_reg <= clip_reg || vps_pkg::clip32(64'(mq));
                    step_reg <= P_HX;
                end
                P_HX:
                begin
                    hx_reg   <= vps_pkg::sat32(64'(mq >>> 1));
                    clip_reg <= clip_reg || vps_pkg::clip32(64'(mq >>> 1));
                    step_reg <= P_HZ;
                end
                P_HZ:
                begin
                    hz_reg   <= vps_pkg::sat32(64'(mq >>> 1));
                    clip_reg <= clip_reg || vps_pkg::clip32(64'(mq >>> 1));
                    step_reg <= P_T1;
                end
                P_T1, P_T2, P_T3:
                begin
                    t_reg    <= vps_pkg::sat32(64'(mq));
                    clip_reg <= clip_reg || vps_pkg::clip32(64'(mq));
                    step_reg <= (step_reg == P_T1) ? P_T2 : (step_reg == P_T2) ? P_T3 : P_NX;
                end
                P_SVZ, P_STH:
                begin
                    if (k_reg == KW'(STENCIL_HALF - 1))
                    begin
                        acc_reg  <= '0;
                        k_reg    <= '0;
                        clip_reg <= clip_reg || vps_pkg::clip32(64'(acc_sum));
                        if (step_reg == P_SVZ)
                        begin
                            sv_reg   <= vps_pkg::sat32(64'(acc_sum));
                            step_reg <= P_STH;
                        end
                        else
                        begin
                            st_reg   <= vps_pkg::sat32(64'(acc_sum));
                            step_reg <= P_PA1;
                        end
                    end
                    else
                    begin
                        acc_reg <= acc_sum;
                        k_reg   <= k_reg + KW'(1);
                    end
                end
                P_PA1, P_PA2, P_PA3:
                begin
                    pa_reg   <= vps_pkg::sat32(64'(mq));
                    clip_reg <= clip_reg || vps_pkg::clip32(64'(mq));
                    step_reg <= (step_reg == P_PA1) ? P_PA2 : (step_reg == P_PA2) ? P_PA3 : P_PB1;
                end
                P_PB1, P_PB2, P_PB3, P_PB4:
                begin
                    pb_reg   <= vps_pkg::sat32(64'(mq));
                    clip_reg <= clip_reg || vps_pkg::clip32(64'(mq));
                    step_reg <= (step_reg == P_PB1) ? P_PB2 :
                                (step_reg == P_PB2) ? P_PB3 :
                                (step_reg == P_PB3) ? P_PB4 : P_NZ;
                end
                P_SRC:
                begin
                    if (item_reg.source_here)
                    begin
                        src_reg  <= vps_pkg::sat32(64'(mq));
                        clip_reg <= clip_reg || vps_pkg::clip32(64'(mq));
                    end
                    else
                        src_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // output register
    assign p_sum    = 64'(px_reg) + 64'(pz_reg) + 64'(src_reg);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.px_next   <= px_reg;
            out_data_reg.pz_next   <= pz_reg;
            out_data_reg.p_next    <= vps_pkg::sat32(p_sum);
            out_data_reg.saturated <= clip_reg || vps_pkg::clip32(p_sum);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
